FILE: src/lpht_pkg.sv
package lpht_pkg;

    // defaults for the top level parameters
    localparam int DEF_TABLE_SLOTS = 16;
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_HANDLE_BITS = 16;

    // word field widths
    localparam int MODE_W      = 2;
    localparam int KEY_W       = 64;
    localparam int HANDLE_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 4;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 24;

    // command codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // slot states
    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_USED    = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    // result codes
    localparam logic [STATUS_W-1:0] RES_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] RES_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] RES_FULL     = 2'd2;

endpackage

FILE: src/linear_probe_hash_table_top.sv
// open addressing hash table with linear probing. each input word is an insert, lookup or
// delete of a zero terminated key of up to KEY_BYTES bytes; each command gives exactly one
// result word (status, handle, slot). the home slot is sum = ((sum + b) * b) mod TABLE_SLOTS
// over the key bytes, worked one byte per step; probing then reads one slot per cycle from a
// single slot memory (status, key and handle in one word), wrapping at the end of the table.
// with TABLE_SLOTS a power of two each key byte is reduced by keeping the low product bits;
// otherwise it runs through multiply, reciprocal estimate, back multiply and correct.
// probing reads 1 to TABLE_SLOTS slots; the unused mode code skips the table as a miss.
// commands are handled one at a time; a finished result waits in the output register while
// the next command is taken. after reset a clearing pass marks every slot empty; no command
// is taken until it is done.
module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = lpht_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BYTES   = lpht_pkg::DEF_KEY_BYTES,
    parameter int HANDLE_BITS = lpht_pkg::DEF_HANDLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command channel
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // mode [1:0], key [65:2], handle_in [81:66], zero fill [87:82]
    input  logic [lpht_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // result channel
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status [1:0], handle_out [17:2], slot [21:18], zero fill [23:22]
    output logic [lpht_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int L      = $clog2(TABLE_SLOTS);           // slot index width
    localparam int KW     = 8 * KEY_BYTES;                 // stored key width
    localparam int HB     = HANDLE_BITS;
    localparam int SUMB_W = $clog2(TABLE_SLOTS + 255);     // sum + byte
    localparam int PW     = SUMB_W + 8;                    // (sum + byte) * byte
    localparam int MW     = PW + 1;                        // reciprocal width
    localparam int SH     = PW + L;                        // reciprocal shift
    localparam bit IS_POW2 = ((1 << L) == TABLE_SLOTS);
    localparam longint unsigned C_RECIP_L = (64'd1 << SH) / TABLE_SLOTS;
    localparam logic [MW-1:0]   C_RECIP   = MW'(C_RECIP_L);
    localparam logic [PW-1:0]   C_SLOTS   = PW'(TABLE_SLOTS);
    localparam logic [L-1:0]    C_LAST    = L'(TABLE_SLOTS - 1);

    // sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_QEST   = 4'd3;
    localparam logic [3:0] S_QN     = 4'd4;
    localparam logic [3:0] S_SUB    = 4'd5;
    localparam logic [3:0] S_START  = 4'd6;
    localparam logic [3:0] S_PROBE  = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    typedef struct packed {
        logic [1:0]    st;
        logic [KW-1:0] key;
        logic [HB-1:0] hdl;
    } t_entry;

    // slot memory
    t_entry        r_mem [TABLE_SLOTS];
    t_entry        r_rdata;
    logic          w_we;
    logic [L-1:0]  w_waddr;
    t_entry        w_wdata;
    logic [L-1:0]  w_raddr;

    logic [3:0]                       r_state,     n_state;
    logic [lpht_pkg::MODE_W-1:0]      r_mode,      n_mode;
    logic [KW-1:0]                    r_key,       n_key;
    logic [KW-1:0]                    r_hkey,      n_hkey;
    logic [HB-1:0]                    r_hdl,       n_hdl;
    logic [L-1:0]                     r_sum,       n_sum;
    logic [PW-1:0]                    r_prod,      n_prod;
    logic [PW-1:0]                    r_q,         n_q;
    logic [PW-1:0]                    r_qn,        n_qn;
    logic [L-1:0]                     r_paddr,     n_paddr;
    logic [L-1:0]                     r_cnt,       n_cnt;
    logic [lpht_pkg::STATUS_W-1:0]    r_res_st,    n_res_st;
    logic [HB-1:0]                    r_res_hdl,   n_res_hdl;
    logic [L-1:0]                     r_slot,      n_slot;
    logic                             r_wr,        n_wr;
    logic [1:0]                       r_wst,       n_wst;
    logic                             r_out_valid, n_out_valid;
    logic [lpht_pkg::OUT_TDATA_W-1:0] r_out_data,  n_out_data;

    logic                        w_accept;
    logic                        w_out_free;
    logic [KW-1:0]               w_canon;
    logic [7:0]                  w_byte;
    logic [SUMB_W-1:0]           w_sb;
    logic [PW-1:0]               w_p;
    logic [PW+MW-1:0]            w_pm;
    logic [2*PW-1:0]             w_qnp;
    logic [PW-1:0]               w_rem;
    logic [L-1:0]                w_next;
    logic                        w_key_eq;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // cut the key at the first zero byte
    always_comb begin
        logic alive;
        alive   = 1'b1;
        w_canon = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            alive = alive && (i_s_axis_tdata[lpht_pkg::MODE_W + 8*i +: 8] != 8'd0);
            if (alive) begin
                w_canon[8*i +: 8] = i_s_axis_tdata[lpht_pkg::MODE_W + 8*i +: 8];
            end
        end
    end

    // hash datapath
    assign w_byte = r_hkey[7:0];
    assign w_sb   = SUMB_W'(r_sum) + SUMB_W'(w_byte);
    assign w_p    = PW'(w_sb) * PW'(w_byte);
    assign w_pm   = {{MW{1'b0}}, r_prod} * {{PW{1'b0}}, C_RECIP};
    assign w_qnp  = {{PW{1'b0}}, r_q} * {{PW{1'b0}}, C_SLOTS};
    assign w_rem  = r_prod - r_qn;

    // probe datapath
    assign w_next   = (r_paddr == C_LAST) ? '0 : r_paddr + 1'b1;
    assign w_key_eq = (r_rdata.key == r_key);

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_slot;
        w_wdata = '{st: r_wst, key: r_key, hdl: r_hdl};
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_paddr;
            w_wdata = '{st: lpht_pkg::SLOT_EMPTY, key: '0, hdl: '0};
        end else if (r_state == S_RESULT && w_out_free && r_wr) begin
            w_we = 1'b1;
        end
    end
    assign w_raddr = (r_state == S_START) ? r_sum : w_next;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_key       = r_key;
        n_hkey      = r_hkey;
        n_hdl       = r_hdl;
        n_sum       = r_sum;
        n_prod      = r_prod;
        n_q         = r_q;
        n_qn        = r_qn;
        n_paddr     = r_paddr;
        n_cnt       = r_cnt;
        n_res_st    = r_res_st;
        n_res_hdl   = r_res_hdl;
        n_slot      = r_slot;
        n_wr        = r_wr;
        n_wst       = r_wst;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_paddr = w_next;
                if (r_paddr == C_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_mode    = i_s_axis_tdata[lpht_pkg::MODE_W-1:0];
                    n_key     = w_canon;
                    n_hkey    = w_canon;
                    n_hdl     = HB'(i_s_axis_tdata[lpht_pkg::MODE_W + lpht_pkg::KEY_W +:
                                                   lpht_pkg::HANDLE_W]);
                    n_sum     = '0;
                    n_res_st  = lpht_pkg::RES_NOTFOUND;
                    n_res_hdl = '0;
                    n_slot    = '0;
                    n_wr      = 1'b0;
                    if (i_s_axis_tdata[lpht_pkg::MODE_W-1:0] == lpht_pkg::MODE_INSERT ||
                        i_s_axis_tdata[lpht_pkg::MODE_W-1:0] == lpht_pkg::MODE_LOOKUP ||
                        i_s_axis_tdata[lpht_pkg::MODE_W-1:0] == lpht_pkg::MODE_DELETE) begin
                        n_state = S_HASH;
                    end else begin
                        // unused code: no table access, reported as a miss
                        n_state = S_RESULT;
                    end
                end
            end
            S_HASH: begin
                if (w_byte == 8'd0) begin
                    n_state = S_START;
                end else if (IS_POW2) begin
                    n_sum  = w_p[L-1:0];
                    n_hkey = r_hkey >> 8;
                end else begin
                    n_prod  = w_p;
                    n_state = S_QEST;
                end
            end
            S_QEST: begin
                // quotient estimate, low by at most one
                n_q     = PW'(w_pm >> SH);
                n_state = S_QN;
            end
            S_QN: begin
                n_qn    = PW'(w_qnp);
                n_state = S_SUB;
            end
            S_SUB: begin
                n_sum   = (w_rem >= C_SLOTS) ? L'(w_rem - C_SLOTS) : L'(w_rem);
                n_hkey  = r_hkey >> 8;
                n_state = S_HASH;
            end
            S_START: begin
                n_paddr = r_sum;
                n_cnt   = '0;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                // r_rdata holds slot r_paddr; slot w_next is being read
                if (r_mode == lpht_pkg::MODE_INSERT) begin
                    if (r_rdata.st != lpht_pkg::SLOT_USED) begin
                        n_res_st = lpht_pkg::RES_OK;
                        n_slot   = r_paddr;
                        n_wr     = 1'b1;
                        n_wst    = lpht_pkg::SLOT_USED;
                        n_state  = S_RESULT;
                    end else if (r_cnt == C_LAST) begin
                        n_res_st = lpht_pkg::RES_FULL;
                        n_state  = S_RESULT;
                    end else begin
                        n_paddr = w_next;
                        n_cnt   = r_cnt + 1'b1;
                    end
                end else begin
                    if (r_rdata.st == lpht_pkg::SLOT_EMPTY) begin
                        n_state = S_RESULT;
                    end else if (r_rdata.st != lpht_pkg::SLOT_DELETED && w_key_eq) begin
                        n_res_st  = lpht_pkg::RES_OK;
                        n_res_hdl = r_rdata.hdl;
                        n_hdl     = r_rdata.hdl;
                        n_slot    = r_paddr;
                        n_wr      = (r_mode == lpht_pkg::MODE_DELETE);
                        n_wst     = lpht_pkg::SLOT_DELETED;
                        n_state   = S_RESULT;
                    end else if (r_cnt == C_LAST) begin
                        n_state = S_RESULT;
                    end else begin
                        n_paddr = w_next;
                        n_cnt   = r_cnt + 1'b1;
                    end
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = lpht_pkg::OUT_TDATA_W'({
                        lpht_pkg::SLOT_OUT_W'(r_slot),
                        lpht_pkg::HANDLE_W'(r_res_hdl),
                        r_res_st});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_paddr     <= '0;
            r_out_valid <= 1'b0;
            r_wr        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_paddr     <= n_paddr;
            r_out_valid <= n_out_valid;
            r_wr        <= n_wr;
        end
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_hkey     <= n_hkey;
        r_hdl      <= n_hdl;
        r_sum      <= n_sum;
        r_prod     <= n_prod;
        r_q        <= n_q;
        r_qn       <= n_qn;
        r_cnt      <= n_cnt;
        r_res_st   <= n_res_st;
        r_res_hdl  <= n_res_hdl;
        r_slot     <= n_slot;
        r_wst      <= n_wst;
        r_out_data <= n_out_data;
    end

endmodule

FILE: dv/tb_linear_probe_hash_table_top.sv
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_top;

    localparam int SLOTS        = lpht_pkg::DEF_TABLE_SLOTS;
    localparam int KEY_LEN      = lpht_pkg::DEF_KEY_BYTES;
    // no operation code, the package names only the three commands
    localparam logic [lpht_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int RANDOM_WORDS = 1850;
    localparam int POOL_SIZE    = 20;
    localparam int DIR_ROWS     = 24;
    // idle cycles with no handshake on either side before the run is called hung
    localparam int STALL_LIMIT  = 2000;
    // wait after the last expected result word, longer than the longest command
    localparam int DRAIN_CYCLES = 60;

    // laid out as the result word: status in the low bits, slot on top
    typedef struct packed {
        logic [lpht_pkg::SLOT_OUT_W-1:0] slot;
        logic [lpht_pkg::HANDLE_W-1:0]   handle;
        logic [lpht_pkg::STATUS_W-1:0]   status;
    } t_lookup_res;

    // one directed command, with the result typed in where it is obvious
    typedef struct {
        logic [lpht_pkg::MODE_W-1:0]     mode;
        logic [lpht_pkg::KEY_W-1:0]      key;
        logic [lpht_pkg::HANDLE_W-1:0]   handle;
        bit                              fixed;
        logic [lpht_pkg::STATUS_W-1:0]   exp_status;
        logic [lpht_pkg::HANDLE_W-1:0]   exp_handle;
        logic [lpht_pkg::SLOT_OUT_W-1:0] exp_slot;
    } t_cmd_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    logic [lpht_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    logic [lpht_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    // shadow copy of the slot memory
    logic [1:0]                    shadow_state [SLOTS];
    logic [lpht_pkg::KEY_W-1:0]    shadow_key   [SLOTS];
    logic [lpht_pkg::HANDLE_W-1:0] shadow_hdl   [SLOTS];

    t_lookup_res pending_results[$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          rx_hold      = 0;
    bit          quiet_run;

    t_cmd_row                   dir_tab  [DIR_ROWS];
    logic [lpht_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    int                         pool_len [POOL_SIZE];

    linear_probe_hash_table_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // key cut at the first zero byte
    function automatic logic [lpht_pkg::KEY_W-1:0] trim_key(
        input logic [lpht_pkg::KEY_W-1:0] k);
        logic [lpht_pkg::KEY_W-1:0] r;
        r = '0;
        for (int i = 0; i < KEY_LEN; i++) begin
            if (k[8*i +: 8] == 8'd0) break;
            r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    // home slot: sum = ((sum + b) * b) mod SLOTS over the bytes of a trimmed key
    function automatic int unsigned hash_home(input logic [lpht_pkg::KEY_W-1:0] k);
        int unsigned sum;
        int unsigned b;
        sum = 0;
        for (int i = 0; i < 8; i++) begin
            b = k[8*i +: 8];
            if (b == 0) break;
            sum = ((sum + b) * b) % SLOTS;
        end
        return sum;
    endfunction

    // apply one command to the shadow table and return the result word it must produce
    function automatic t_lookup_res table_apply(input logic [lpht_pkg::MODE_W-1:0] mode,
                                                input logic [lpht_pkg::KEY_W-1:0] raw_key,
                                                input logic [lpht_pkg::HANDLE_W-1:0] hdl);
        t_lookup_res                r;
        logic [lpht_pkg::KEY_W-1:0] k;
        int unsigned                home;
        int unsigned                s;
        r = '{status: lpht_pkg::RES_NOTFOUND, handle: '0, slot: '0};
        k = trim_key(raw_key);
        home = hash_home(k);
        if (mode == lpht_pkg::MODE_INSERT) begin
            r.status = lpht_pkg::RES_FULL;
            for (int i = 0; i < SLOTS; i++) begin
                s = (home + i) % SLOTS;
                if (shadow_state[s] != lpht_pkg::SLOT_USED) begin
                    shadow_state[s] = lpht_pkg::SLOT_USED;
                    shadow_key[s]   = k;
                    shadow_hdl[s]   = hdl;
                    r.status = lpht_pkg::RES_OK;
                    r.slot   = s[lpht_pkg::SLOT_OUT_W-1:0];
                    break;
                end
            end
        end else if (mode == lpht_pkg::MODE_LOOKUP || mode == lpht_pkg::MODE_DELETE) begin
            // stop at an empty slot, skip tombstones
            for (int i = 0; i < SLOTS; i++) begin
                s = (home + i) % SLOTS;
                if (shadow_state[s] == lpht_pkg::SLOT_EMPTY) break;
                if (shadow_state[s] == lpht_pkg::SLOT_USED && shadow_key[s] == k) begin
                    r.status = lpht_pkg::RES_OK;
                    r.handle = shadow_hdl[s];
                    r.slot   = s[lpht_pkg::SLOT_OUT_W-1:0];
                    if (mode == lpht_pkg::MODE_DELETE) shadow_state[s] = lpht_pkg::SLOT_DELETED;
                    break;
                end
            end
        end
        return r;
    endfunction

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // drive one command word at the falling edge, hold it until taken, then log
    // the result word it must cause
    task automatic send_word(input logic [lpht_pkg::MODE_W-1:0] mode,
                             input logic [lpht_pkg::KEY_W-1:0] key,
                             input logic [lpht_pkg::HANDLE_W-1:0] hdl, input bit fixed,
                             input t_lookup_res fixed_res, input int gap);
        t_lookup_res r;
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {6'b0, hdl, key, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        // the shadow table is updated even when the expected word is typed in
        r = table_apply(mode, key, hdl);
        pending_results.push_back(fixed ? fixed_res : r);
        @(negedge i_clk);
    endtask

    // result side: random back pressure, released during quiet stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready = 1'b0;
        end else if (rx_hold > 0 && !quiet_run) begin
            i_m_axis_tready = 1'b0;
            rx_hold--;
        end else begin
            i_m_axis_tready = 1'b1;
            rx_hold = 0;
            if (!quiet_run && $urandom_range(0, 99) < 25) rx_hold = idle_len();
        end
    end

    // compare each accepted result word with the oldest pending one
    always @(posedge i_clk) begin
        t_lookup_res got;
        t_lookup_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[21:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none pending: status %0d handle %h slot %0d",
                         $time, got.status, got.handle, got.slot);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || o_m_axis_tdata[23:22] !== 2'b00) begin
                    mismatches++;
                    $display("%0t: exp st %0d hdl %h slot %0d, got st %0d hdl %h slot %0d fill %b",
                             $time, want.status, want.handle, want.slot,
                             got.status, got.handle, got.slot, o_m_axis_tdata[23:22]);
                end
            end
        end
    end

    // hang detector: counts cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_lookup_res                 none;
        logic [lpht_pkg::MODE_W-1:0] mode;
        logic [lpht_pkg::KEY_W-1:0]  key;
        int                          pick;
        int                          phase;
        int                          len;
        int                          r;

        none = '{status: lpht_pkg::RES_OK, handle: '0, slot: '0};
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        quiet_run       = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_state[i] = lpht_pkg::SLOT_EMPTY;
            shadow_key[i]   = '0;
            shadow_hdl[i]   = '0;
        end

        // directed commands; fixed rows carry a typed-in result
        dir_tab[0]  = '{lpht_pkg::MODE_LOOKUP, 64'h0, 16'h0000, 1'b1,
                        lpht_pkg::RES_NOTFOUND, 16'h0, 4'd0};
        dir_tab[1]  = '{MODE_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
                        lpht_pkg::RES_NOTFOUND, 16'h0, 4'd0};
        // empty key hashes to slot zero
        dir_tab[2]  = '{lpht_pkg::MODE_INSERT, 64'h0, 16'hFFFF, 1'b1,
                        lpht_pkg::RES_OK, 16'h0, 4'd0};
        // duplicate insert takes another slot
        dir_tab[3]  = '{lpht_pkg::MODE_INSERT, 64'h0, 16'h1234, 1'b0,
                        lpht_pkg::RES_OK, 16'h0, 4'd0};
        dir_tab[4]  = '{lpht_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b0,
                        lpht_pkg::RES_OK, 16'h0, 4'd0};
        // garbage past the terminator is ignored, so this removes the empty key
        dir_tab[5]  = '{lpht_pkg::MODE_DELETE, 64'hA5A5_0000_0000_0000, 16'hBEEF, 1'b0,
                        lpht_pkg::RES_OK, 16'h0, 4'd0};
        // lookup walks over the tombstone to the duplicate
        dir_tab[6]  = '{lpht_pkg::MODE_LOOKUP, 64'h0, 16'h0, 1'b0,
                        lpht_pkg::RES_OK, 16'h0, 4'd0};
        dir_tab[7]  = '{lpht_pkg::MODE_INSERT, 64'h5A00_0000_0000_0041, 16'h8001, 1'b0,
                        lpht_pkg::RES_OK, 16'h0, 4'd0};
        dir_tab[8]  = '{lpht_pkg::MODE_DELETE, 64'h4242, 16'h0, 1'b0,
                        lpht_pkg::RES_OK, 16'h0, 4'd0};
        // fill the rest of the table
        for (int i = 0; i < 13; i++)
            dir_tab[9+i] = '{lpht_pkg::MODE_INSERT, 64'h3100 + 64'(i) * 64'h0101 + 64'h31,
                             16'(16'h1111 * (i + 1)), 1'b0, lpht_pkg::RES_OK, 16'h0, 4'd0};
        dir_tab[22] = '{lpht_pkg::MODE_INSERT, 64'h7A7A, 16'hAAAA, 1'b1,
                        lpht_pkg::RES_FULL, 16'h0, 4'd0};
        // miss on a full table, every slot probed
        dir_tab[23] = '{lpht_pkg::MODE_LOOKUP, 64'hFE_FEFE, 16'h5555, 1'b0,
                        lpht_pkg::RES_OK, 16'h0, 4'd0};

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i])
            send_word(dir_tab[i].mode, dir_tab[i].key, dir_tab[i].handle, dir_tab[i].fixed,
                      '{status: dir_tab[i].exp_status, handle: dir_tab[i].exp_handle,
                        slot: dir_tab[i].exp_slot},
                      ($urandom_range(0, 1) == 0) ? 0 : idle_len());

        // pool of keys, few enough that probes collide and lookups hit
        for (int p = 0; p < POOL_SIZE; p++) begin
            r = $urandom_range(0, 19);
            pool_len[p] = (r == 0) ? 0 : (r < 5) ? KEY_LEN : $urandom_range(1, KEY_LEN - 1);
            key_pool[p] = '0;
            for (int b = 0; b < pool_len[p]; b++)
                key_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet_run = ((n / 100) % 5) == 3;
            // phases lean toward filling, mixing and emptying the table
            phase = (n / 150) % 3;
            r = $urandom_range(0, 99);
            if (r < 4)
                mode = MODE_NOP;
            else if (r < ((phase == 0) ? 60 : (phase == 1) ? 40 : 25))
                mode = lpht_pkg::MODE_INSERT;
            else if (r < ((phase == 0) ? 80 : (phase == 1) ? 70 : 50))
                mode = lpht_pkg::MODE_LOOKUP;
            else
                mode = lpht_pkg::MODE_DELETE;

            if ($urandom_range(0, 9) == 0) begin
                // noise: a fully random key
                key = {$urandom, $urandom};
            end else begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                key  = key_pool[pick];
                len  = pool_len[pick];
                // junk after the terminator, the terminator byte itself stays zero
                if (len < KEY_LEN - 1 && $urandom_range(0, 2) == 0)
                    for (int b = len + 1; b < KEY_LEN; b++)
                        key[8*b +: 8] = 8'($urandom);
            end

            send_word(mode, key, 16'($urandom), 1'b0, none,
                      (quiet_run || $urandom_range(0, 1) == 0) ? 0 : idle_len());
        end
        i_s_axis_tvalid = 1'b0;
        quiet_run = 1'b0;

        // drain, then watch for stray result words
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
